// ===== rtl/core/dfp_pkg.sv =====
// ----------------------------------------------------------------------------
// dfp_pkg - shared types and constants of the draughts position parser
// Character codes, parser phases, error codes and the parser state record.
// ----------------------------------------------------------------------------
`default_nettype none

package dfp_pkg;

  localparam int Squares    = 50;
  localparam int PromoWidth = 5;   // squares on one promotion row

  // character codes
  localparam logic [7:0] ChNul   = 8'h00;
  localparam logic [7:0] ChQuote = 8'h22;
  localparam logic [7:0] ChComma = 8'h2C;
  localparam logic [7:0] ChDash  = 8'h2D;
  localparam logic [7:0] ChDot   = 8'h2E;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;
  localparam logic [7:0] ChColon = 8'h3A;
  localparam logic [7:0] ChB     = 8'h42;
  localparam logic [7:0] ChK     = 8'h4B;
  localparam logic [7:0] ChW     = 8'h57;

  // parser phases
  localparam logic [1:0] PhSide   = 2'd0;
  localparam logic [1:0] PhColon  = 2'd1;
  localparam logic [1:0] PhColour = 2'd2;
  localparam logic [1:0] PhBody   = 2'd3;

  // number stages
  localparam logic [1:0] NsNone   = 2'd0;
  localparam logic [1:0] NsFirst  = 2'd1;
  localparam logic [1:0] NsDash   = 2'd2;
  localparam logic [1:0] NsSecond = 2'd3;

  // error codes
  localparam logic [2:0] ErrNone   = 3'd0;
  localparam logic [2:0] ErrSide   = 3'd1;
  localparam logic [2:0] ErrColon  = 3'd2;
  localparam logic [2:0] ErrColour = 3'd3;
  localparam logic [2:0] ErrRange  = 3'd4;
  localparam logic [2:0] ErrDash   = 3'd5;
  localparam logic [2:0] ErrChar   = 3'd6;
  localparam logic [2:0] ErrPromo  = 3'd7;

  localparam logic [5:0] NumSat = 6'd63;

  typedef logic [Squares-1:0] dfp_map_t;

  typedef struct packed {
    logic [1:0] phase;
    logic       colour;
    logic       king;
    logic [5:0] first_num;
    logic [5:0] second_num;
    logic [1:0] nstage;
    dfp_map_t   wm;
    dfp_map_t   wk;
    dfp_map_t   bm;
    dfp_map_t   bk;
    logic       side;
    logic [2:0] err;
    logic       ended;
  } dfp_state_t;

  typedef struct packed {
    dfp_map_t   white_men;
    dfp_map_t   white_kings;
    dfp_map_t   black_men;
    dfp_map_t   black_kings;
    logic       side_to_move;
    logic [2:0] error_code;
  } dfp_result_t;

  localparam dfp_state_t StateReset = '{
    phase:      PhSide,
    colour:     1'b0,
    king:       1'b0,
    first_num:  6'd0,
    second_num: 6'd0,
    nstage:     NsNone,
    wm:         '0,
    wk:         '0,
    bm:         '0,
    bk:         '0,
    side:       1'b0,
    err:        ErrNone,
    ended:      1'b0
  };

endpackage

`default_nettype wire

// ===== rtl/core/dfp_if.sv =====
// ----------------------------------------------------------------------------
// dfp_if - stream channels of the draughts position parser
// Character channel in, result channel out; valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface dfp_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       last_char;

  modport source (output valid, output char_code, output last_char, input ready);
  modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

interface dfp_res_if;
  import dfp_pkg::*;
  logic       valid;
  logic       ready;
  dfp_map_t   white_men;
  dfp_map_t   white_kings;
  dfp_map_t   black_men;
  dfp_map_t   black_kings;
  logic       side_to_move;
  logic [2:0] error_code;

  modport source (output valid, output white_men, output white_kings, output black_men,
                  output black_kings, output side_to_move, output error_code,
                  input ready);
  modport sink   (input valid, input white_men, input white_kings, input black_men,
                  input black_kings, input side_to_move, input error_code,
                  output ready);
endinterface

`default_nettype wire

// ===== rtl/core/dfp_step.sv =====
// ----------------------------------------------------------------------------
// dfp_step - one character of parsing
// Next parser state from the current state and one character; on the last
// character also the finished result, and the state returns to reset.
// ----------------------------------------------------------------------------
`default_nettype none

module dfp_step (
  input  dfp_pkg::dfp_state_t  st_i,
  input  logic [7:0]           char_i,
  input  logic                 last_i,
  output dfp_pkg::dfp_state_t  st_o,
  output dfp_pkg::dfp_result_t res_o
);
  import dfp_pkg::*;

  localparam int MaskW = Squares + 1;

  function automatic logic in_range(input logic [5:0] n);
    return (n != 6'd0) && (n <= 6'(Squares));
  endfunction

  function automatic logic [5:0] accumulate(input logic [5:0] n, input logic [3:0] dg);
    logic [9:0] v;
    v = 10'(n) * 10'd10 + 10'(dg);
    return (v > 10'(NumSat)) ? NumSat : v[5:0];
  endfunction

  function automatic dfp_state_t record(input dfp_state_t s, input logic [2:0] code);
    dfp_state_t r;
    r = s;
    if (r.err == ErrNone) r.err = code;
    r.ended = 1'b1;
    return r;
  endfunction

  // pieces on squares lo..hi, nothing when lo > hi
  function automatic dfp_state_t place(input dfp_state_t s, input logic [5:0] lo,
                                       input logic [5:0] hi);
    dfp_state_t     r;
    logic [MaskW-1:0] hi_m;
    logic [MaskW-1:0] lo_m;
    dfp_map_t       m;
    r    = s;
    hi_m = (MaskW'(1) << hi) - MaskW'(1);
    lo_m = (MaskW'(1) << (lo - 6'd1)) - MaskW'(1);
    m    = Squares'(hi_m ^ lo_m);
    if (lo <= hi) begin
      r.wm = r.wm & ~m;
      r.wk = r.wk & ~m;
      r.bm = r.bm & ~m;
      r.bk = r.bk & ~m;
      if (!r.colour) begin
        if (r.king) r.wk = r.wk | m;
        else        r.wm = r.wm | m;
      end else begin
        if (r.king) r.bk = r.bk | m;
        else        r.bm = r.bm | m;
      end
    end
    return r;
  endfunction

  function automatic logic close_ok(input dfp_state_t s);
    return (s.nstage == NsNone) ||
           ((s.nstage != NsDash) && in_range(s.first_num) &&
            ((s.nstage != NsSecond) || in_range(s.second_num)));
  endfunction

  function automatic dfp_state_t close_num(input dfp_state_t s);
    dfp_state_t r;
    r = s;
    if (s.nstage == NsDash) begin
      r = record(s, ErrDash);
    end else if (s.nstage != NsNone) begin
      if (!in_range(s.first_num)) begin
        r = record(s, ErrRange);
      end else if ((s.nstage == NsSecond) && !in_range(s.second_num)) begin
        r = record(s, ErrRange);
      end else begin
        r = place(s, s.first_num, (s.nstage == NsSecond) ? s.second_num : s.first_num);
        r.nstage     = NsNone;
        r.king       = 1'b0;
        r.first_num  = 6'd0;
        r.second_num = 6'd0;
      end
    end
    return r;
  endfunction

  function automatic dfp_state_t body_char(input dfp_state_t s, input logic [7:0] c);
    dfp_state_t r;
    logic       dig;
    logic [3:0] dv;
    r   = s;
    dig = (c >= ChZero) && (c <= ChNine);
    dv  = dig ? c[3:0] : 4'd0;
    if ((s.nstage == NsFirst) && dig) begin
      r.first_num = accumulate(s.first_num, dv);
    end else if ((s.nstage == NsFirst) && (c == ChDash)) begin
      if (!in_range(s.first_num)) r = record(s, ErrRange);
      else                        r.nstage = NsDash;
    end else if (s.nstage == NsDash) begin
      if (dig) begin
        r.second_num = 6'(dv);
        r.nstage     = NsSecond;
      end else begin
        r = record(s, ErrDash);
      end
    end else if ((s.nstage == NsSecond) && dig) begin
      r.second_num = accumulate(s.second_num, dv);
    end else if (close_ok(s)) begin
      r = close_num(s);
      if ((c == ChDot) || (c == ChQuote) || (c == ChNul)) begin
        r.ended = 1'b1;
      end else if (c == ChW) begin
        r.colour = 1'b0;
      end else if (c == ChB) begin
        r.colour = 1'b1;
      end else if (c == ChK) begin
        r.king = 1'b1;
      end else if (dig) begin
        r.first_num = 6'(dv);
        r.nstage    = NsFirst;
      end else if ((c != ChComma) && (c != ChColon)) begin
        r = record(r, ErrChar);
      end
    end else begin
      r = close_num(s);
    end
    return r;
  endfunction

  dfp_state_t s;

  always_comb begin
    s = st_i;
    if (!s.ended) begin
      case (s.phase)
        PhSide: begin
          if      (char_i == ChW) begin s.side = 1'b0; s.phase = PhColon; end
          else if (char_i == ChB) begin s.side = 1'b1; s.phase = PhColon; end
          else    s = record(s, ErrSide);
        end
        PhColon: begin
          if (char_i == ChColon) s.phase = PhColour;
          else                   s = record(s, ErrColon);
        end
        PhColour: begin
          if      (char_i == ChW) begin s.colour = 1'b0; s.phase = PhBody; end
          else if (char_i == ChB) begin s.colour = 1'b1; s.phase = PhBody; end
          else    s = record(s, ErrColour);
        end
        default: s = body_char(s, char_i);
      endcase
    end

    // end of string: flush what is pending, then the promotion row check
    if (last_i) begin
      if (!s.ended) begin
        case (s.phase)
          PhSide:   s = record(s, ErrSide);
          PhColon:  s = record(s, ErrColon);
          PhColour: s = record(s, ErrColour);
          default:  s = close_num(s);
        endcase
      end
      if ((s.err == ErrNone) &&
          ((s.wm[PromoWidth-1:0] != '0) ||
           (s.bm[Squares-1:Squares-PromoWidth] != '0))) begin
        s.err = ErrPromo;
      end
    end
  end

  assign res_o.white_men    = s.wm;
  assign res_o.white_kings  = s.wk;
  assign res_o.black_men    = s.bm;
  assign res_o.black_kings  = s.bk;
  assign res_o.side_to_move = s.side;
  assign res_o.error_code   = s.err;
  assign st_o               = last_i ? StateReset : s;

endmodule

`default_nettype wire

// ===== rtl/core/draughts_fen_parser.sv =====
// ----------------------------------------------------------------------------
// draughts_fen_parser - streaming parser for 10x10 draughts position strings
// One character per transfer; the last character yields the four piece maps,
// the side to move and the first error seen.
// Result path: the last character's transfer loads the input register, and
//   its parser step loads the result register once that has room.
// Throughput: one character per cycle; a last character waits only while an
//   earlier result is still held.
// Reset: asynchronous, active low; clears the parser state, both valid flags.
// ----------------------------------------------------------------------------
`default_nettype none

module draughts_fen_parser (
  input  logic      clk_i,
  input  logic      rst_ni,
  dfp_char_if.sink  chr_i,
  dfp_res_if.source res_o
);
  import dfp_pkg::*;

  // Input register: holds one character until the parser step consumes it.
  logic       in_vld_q, in_vld_d;
  logic [7:0] in_char_q;
  logic       in_last_q;

  // Parser state, advanced once per consumed character.
  dfp_state_t st_q, st_d;

  // Result register: decouples the parser from a stalled result sink.
  logic        res_vld_q, res_vld_d;
  dfp_result_t res_q, res_step;

  logic in_fire;   // character leaves the input register into the parser
  logic in_take;   // transfer on the character channel

  // A plain character always proceeds; a last character needs room in the
  // result register (empty, or being drained in this very cycle).
  assign in_fire     = in_vld_q && (!in_last_q || !res_vld_q || res_o.ready);
  assign chr_i.ready = !in_vld_q || in_fire;
  assign in_take     = chr_i.valid && chr_i.ready;

  dfp_step u_step (
    .st_i   (st_q),
    .char_i (in_char_q),
    .last_i (in_last_q),
    .st_o   (st_d),
    .res_o  (res_step)
  );

  always_comb begin
    in_vld_d = in_vld_q;
    if (in_take)      in_vld_d = 1'b1;
    else if (in_fire) in_vld_d = 1'b0;
  end

  always_comb begin
    res_vld_d = res_vld_q;
    if (in_fire && in_last_q) res_vld_d = 1'b1;
    else if (res_o.ready)     res_vld_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      res_vld_q <= 1'b0;
      st_q      <= StateReset;
    end else begin
      in_vld_q  <= in_vld_d;
      res_vld_q <= res_vld_d;
      if (in_fire) st_q <= st_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_char_q <= chr_i.char_code;
      in_last_q <= chr_i.last_char;
    end
    if (in_fire && in_last_q) res_q <= res_step;
  end

  assign res_o.valid        = res_vld_q;
  assign res_o.white_men    = res_q.white_men;
  assign res_o.white_kings  = res_q.white_kings;
  assign res_o.black_men    = res_q.black_men;
  assign res_o.black_kings  = res_q.black_kings;
  assign res_o.side_to_move = res_q.side_to_move;
  assign res_o.error_code   = res_q.error_code;

  // A consumed last character always lands in the result register.
  a_last_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && in_last_q |=> res_vld_q)
    else $error("last character did not produce a result");

  // A character held back keeps its place and value.
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_vld_q && !in_fire |=> in_vld_q && $stable(in_char_q) && $stable(in_last_q))
    else $error("held character lost or changed");

  // Each square holds at most one piece.
  a_maps_disjoint: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_vld_q |-> ((res_q.white_men & res_q.white_kings) == '0) &&
                  (((res_q.white_men | res_q.white_kings) &
                    (res_q.black_men | res_q.black_kings)) == '0) &&
                  ((res_q.black_men & res_q.black_kings) == '0))
    else $error("two pieces on one square");

  // A clean result never has a man on its promotion row.
  a_promo_flagged: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_vld_q && (res_q.error_code == ErrNone) |->
      (res_q.white_men[PromoWidth-1:0] == '0) &&
      (res_q.black_men[Squares-1:Squares-PromoWidth] == '0))
    else $error("man on promotion row not flagged");

endmodule

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top - self-checking bench for the draughts position parser
// Feeds position strings one character per transfer, from directed corner
// strings to random well-formed positions with broken and noise strings mixed
// in. A parser model built into the bench predicts the piece maps, side to
// move and error code for each string. Every result transfer is checked field
// by field, under several sender/receiver idling mixes.
// ----------------------------------------------------------------------------

module tb_top;
  import dfp_pkg::*;

  // run limit in clock cycles
  localparam int CycleLimit = 100000;
  // random characters per idling phase (four phases, about 700 in all)
  localparam int CharsPerPhase = 175;

  typedef struct {
    logic [7:0] code;
    logic       is_last;
  } fen_char_t;

  logic clk_i;
  logic rst_ni;

  dfp_char_if char_bus ();
  dfp_res_if  pos_bus ();

  draughts_fen_parser dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .chr_i  (char_bus),
    .res_o  (pos_bus)
  );

  // characters waiting for the driver, expected positions waiting for the
  // monitor, and the string under construction
  fen_char_t   char_q[$];
  dfp_result_t position_q[$];
  logic [7:0]  str_bytes[$];

  fen_char_t   on_wire;        // character currently presented
  dfp_result_t want_pos;
  dfp_state_t  pz = StateReset; // bench copy of the parser state

  int queued_n;
  int accepted_n;
  int mismatch_n;
  int cycle_n;
  int send_idle_pct;
  int recv_stall_pct;

  // --------------------------------------------------------------------------
  // Parser model
  // --------------------------------------------------------------------------

  // keep only the first error; any error stops parsing until the last char
  function automatic void pz_flag(logic [2:0] code);
    if (pz.err == ErrNone) pz.err = code;
    pz.ended = 1'b1;
  endfunction

  // decimal accumulate with saturation at 63
  function automatic logic [5:0] pz_acc(logic [5:0] n, logic [7:0] c);
    int v;
    v = int'(n) * 10 + int'(c) - int'(ChZero);
    return (v > int'(NumSat)) ? NumSat : 6'(v);
  endfunction

  function automatic bit pz_on_board(logic [5:0] n);
    return (n >= 6'd1) && (int'(n) <= Squares);
  endfunction

  // later piece wins: clear the span in all maps, then set the current kind
  function automatic void pz_place(logic [5:0] lo, logic [5:0] hi);
    dfp_map_t m;
    m = '0;
    if (lo > hi) return;     // descending range places nothing
    for (int i = int'(lo); i <= int'(hi); i++) m[i-1] = 1'b1;
    pz.wm &= ~m;
    pz.wk &= ~m;
    pz.bm &= ~m;
    pz.bk &= ~m;
    if (!pz.colour) begin
      if (pz.king) pz.wk |= m;
      else pz.wm |= m;
    end else begin
      if (pz.king) pz.bk |= m;
      else pz.bm |= m;
    end
  endfunction

  // finish a pending number or range; 0 when that raised an error
  function automatic bit pz_close();
    if (pz.nstage == NsNone) return 1'b1;
    if (pz.nstage == NsDash) begin
      pz_flag(ErrDash);
      return 1'b0;
    end
    if (!pz_on_board(pz.first_num)) begin
      pz_flag(ErrRange);
      return 1'b0;
    end
    if (pz.nstage == NsSecond) begin
      if (!pz_on_board(pz.second_num)) begin
        pz_flag(ErrRange);
        return 1'b0;
      end
      pz_place(pz.first_num, pz.second_num);
    end else begin
      pz_place(pz.first_num, pz.first_num);
    end
    pz.nstage     = NsNone;
    pz.king       = 1'b0;   // king prefix lasts one number or range
    pz.first_num  = '0;
    pz.second_num = '0;
    return 1'b1;
  endfunction

  function automatic void pz_body(logic [7:0] c);
    bit dig;
    dig = (c >= ChZero) && (c <= ChNine);
    if (pz.nstage == NsFirst && dig) begin
      pz.first_num = pz_acc(pz.first_num, c);
      return;
    end
    if (pz.nstage == NsFirst && c == ChDash) begin
      if (!pz_on_board(pz.first_num)) pz_flag(ErrRange);
      else pz.nstage = NsDash;
      return;
    end
    if (pz.nstage == NsDash) begin
      // a dash must be followed directly by a digit
      if (dig) begin
        pz.second_num = 6'(c - ChZero);
        pz.nstage     = NsSecond;
      end else begin
        pz_flag(ErrDash);
      end
      return;
    end
    if (pz.nstage == NsSecond && dig) begin
      pz.second_num = pz_acc(pz.second_num, c);
      return;
    end
    if (!pz_close()) return;
    if (c == ChDot || c == ChQuote || c == ChNul) pz.ended = 1'b1;
    else if (c == ChW) pz.colour = 1'b0;
    else if (c == ChB) pz.colour = 1'b1;
    else if (c == ChK) pz.king = 1'b1;
    else if (dig) begin
      pz.first_num = 6'(c - ChZero);
      pz.nstage    = NsFirst;
    end else if (c != ChComma && c != ChColon) begin
      pz_flag(ErrChar);   // also catches a dash with no number before it
    end
  endfunction

  // one accepted character; the last one queues the expected position
  function automatic void pz_char(logic [7:0] c, logic is_last);
    dfp_result_t r;
    if (!pz.ended) begin
      case (pz.phase)
        PhSide: begin
          if (c == ChW || c == ChB) begin
            pz.side  = (c == ChB);
            pz.phase = PhColon;
          end else begin
            pz_flag(ErrSide);
          end
        end
        PhColon: begin
          if (c == ChColon) pz.phase = PhColour;
          else pz_flag(ErrColon);
        end
        PhColour: begin
          if (c == ChW || c == ChB) begin
            pz.colour = (c == ChB);
            pz.phase  = PhBody;
          end else begin
            pz_flag(ErrColour);
          end
        end
        default: pz_body(c);
      endcase
    end
    if (!is_last) return;
    // early end of string
    if (!pz.ended) begin
      case (pz.phase)
        PhSide:   pz_flag(ErrSide);
        PhColon:  pz_flag(ErrColon);
        PhColour: pz_flag(ErrColour);
        default:  void'(pz_close());
      endcase
    end
    // men on their own promotion row, checked only on a clean string
    if (pz.err == ErrNone &&
        (pz.wm[PromoWidth-1:0] != '0 || pz.bm[Squares-1 -: PromoWidth] != '0))
      pz.err = ErrPromo;
    r.white_men    = pz.wm;
    r.white_kings  = pz.wk;
    r.black_men    = pz.bm;
    r.black_kings  = pz.bk;
    r.side_to_move = pz.side;
    r.error_code   = pz.err;
    position_q.push_back(r);
    pz = StateReset;
  endfunction

  // --------------------------------------------------------------------------
  // String construction
  // --------------------------------------------------------------------------

  function automatic void put_chr(logic [7:0] c);
    str_bytes.push_back(c);
  endfunction

  function automatic void put_str(string s);
    for (int i = 0; i < s.len(); i++) str_bytes.push_back(s[i]);
  endfunction

  // mostly board squares; some just off the board, some long enough to saturate
  function automatic void put_num();
    int sel;
    int n;
    sel = $urandom_range(99);
    if (sel < 80) n = $urandom_range(1, Squares);
    else if (sel < 90) n = $urandom_range(1) ? 0 : $urandom_range(Squares + 1, 99);
    else n = $urandom_range(100, 99999);
    put_str($sformatf("%0d", n));
  endfunction

  function automatic logic [7:0] any_colour();
    return $urandom_range(1) ? ChB : ChW;
  endfunction

  // move the built string to the driver queue, last flag on its final char
  function automatic int send_string();
    fen_char_t fc;
    int n;
    n = str_bytes.size();
    for (int i = 0; i < n; i++) begin
      fc.code    = str_bytes[i];
      fc.is_last = (i == n - 1);
      char_q.push_back(fc);
      queued_n++;
    end
    str_bytes.delete();
    return n;
  endfunction

  // random well-formed position, then maybe broken or replaced by noise
  function automatic int random_string();
    int kind;
    int pos;
    int cnt;
    kind = $urandom_range(99);
    str_bytes.delete();
    if (kind < 10) begin
      cnt = $urandom_range(1, 6);
      for (int i = 0; i < cnt; i++) put_chr(8'($urandom_range(255)));
      return send_string();
    end
    put_chr(any_colour());
    put_chr(ChColon);
    put_chr(any_colour());
    cnt = $urandom_range(1, 6);
    for (int k = 0; k < cnt; k++) begin
      if (k > 0) begin
        put_chr(($urandom_range(3) == 0) ? ChColon : ChComma);
        if ($urandom_range(3) == 0) put_chr(any_colour());
      end
      if ($urandom_range(9) < 3) put_chr(ChK);
      put_num();
      if ($urandom_range(9) < 3) begin
        put_chr(ChDash);
        put_num();
      end
    end
    case ($urandom_range(3))
      0: put_chr(ChDot);
      1: put_chr(ChQuote);
      2: put_chr(ChNul);
      default: ;
    endcase
    // junk at the end; ignored when a terminator came before it
    if ($urandom_range(3) == 0) put_chr(8'($urandom_range(255)));
    if (kind < 30) begin
      pos = $urandom_range(str_bytes.size() - 1);
      case ($urandom_range(3))
        0: str_bytes[pos] = 8'($urandom_range(255));
        1: str_bytes.insert(pos, ($urandom_range(1) ? ChDash : ChComma));
        2: str_bytes.insert(pos, ($urandom_range(1) ? ChK : ChColon));
        default: if (str_bytes.size() > 1) str_bytes.delete(pos);
      endcase
    end
    return send_string();
  endfunction

  // --------------------------------------------------------------------------
  // Clock and timeout
  // --------------------------------------------------------------------------

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) cycle_n <= cycle_n + 1;

  initial begin
    wait (cycle_n >= CycleLimit);
    $display("FAIL");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Character driver: takes the next character only when the previous one
  // has made its transfer (or none is up); random idle cycles per phase.
  // The model sees each character at the edge of its transfer.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      char_bus.valid <= 1'b0;
    end else begin
      if (char_bus.valid && char_bus.ready) begin
        pz_char(on_wire.code, on_wire.is_last);
        accepted_n++;
      end
      if (!char_bus.valid || char_bus.ready) begin
        if (char_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          on_wire = char_q.pop_front();
          char_bus.valid     <= 1'b1;
          char_bus.char_code <= on_wire.code;
          char_bus.last_char <= on_wire.is_last;
        end else begin
          char_bus.valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result side: random back-pressure and field-by-field check of every
  // result transfer against the oldest expected position
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (!rst_ni) pos_bus.ready <= 1'b0;
    else pos_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  function automatic void cmp_field(string fld, logic [Squares-1:0] want,
                                    logic [Squares-1:0] got);
    if (want !== got) begin
      if (mismatch_n < 10)
        $display("mismatch on %s: expected %h, got %h", fld, want, got);
      mismatch_n++;
    end
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && pos_bus.valid && pos_bus.ready) begin
      if (position_q.size() == 0) begin
        if (mismatch_n < 10) $display("result transfer with no position expected");
        mismatch_n++;
      end else begin
        want_pos = position_q.pop_front();
        cmp_field("white_men",    want_pos.white_men,    pos_bus.white_men);
        cmp_field("white_kings",  want_pos.white_kings,  pos_bus.white_kings);
        cmp_field("black_men",    want_pos.black_men,    pos_bus.black_men);
        cmp_field("black_kings",  want_pos.black_kings,  pos_bus.black_kings);
        cmp_field("side_to_move", Squares'(want_pos.side_to_move),
                  Squares'(pos_bus.side_to_move));
        cmp_field("error_code",   Squares'(want_pos.error_code),
                  Squares'(pos_bus.error_code));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sequence: reset, directed strings, then four idling phases of random
  // strings; finally drain the expected positions
  // --------------------------------------------------------------------------
  initial begin
    int fed;
    char_bus.valid     = 1'b0;
    char_bus.char_code = 8'h00;
    char_bus.last_char = 1'b0;
    pos_bus.ready      = 1'b0;
    rst_ni             = 1'b0;
    queued_n       = 0;
    accepted_n     = 0;
    mismatch_n     = 0;
    cycle_n        = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 49; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 49; end
        default: begin send_idle_pct = 21; recv_stall_pct = 21; end
      endcase
      if (ph == 0) begin
        // bad side letter with all bits of the character set
        put_chr(8'hFF);
        void'(send_string());
        // string ends before the colon, then before the colour
        put_str("W");
        void'(send_string());
        put_str("B:");
        void'(send_string());
        // string ends right after a dash
        put_str("W:BK9-");
        void'(send_string());
        // white man on its promotion row, number closed by the end of string
        put_str("B:W1");
        void'(send_string());
        // king prefix across a colour letter, descending range, override,
        // NUL terminator
        put_str("B:KW9-3K9B9");
        put_chr(ChNul);
        void'(send_string());
      end
      fed = 0;
      while (fed < CharsPerPhase) fed += random_string();
      while (accepted_n != queued_n) @(posedge clk_i);
    end

    while (position_q.size() != 0) @(posedge clk_i);
    // result path is two registers deep; let any stray result show up
    repeat (8) @(posedge clk_i);
    if (mismatch_n == 0 && position_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/dfp_pkg.sv
rtl/core/dfp_if.sv
rtl/core/dfp_step.sv
rtl/core/draughts_fen_parser.sv
tb/sv/tb_top.sv
